// ===== hw/rtl/lfsa_pkg.sv =====
// ============================================================================
// lfsa_pkg
// Shared types and codes for the linked free-list slot allocator.
// ============================================================================
package lfsa_pkg;

  // Request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_POOL_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_NOT_ACTIVE = 2'd2;

  // Request word
  typedef struct packed {
    logic       kind;
    logic [4:0] slot;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] granted_slot;
    logic [7:0] slot_number;
    logic [4:0] active_head;
    logic       active_empty;
  } out_word_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_UPD,
    S_REL_HEAD,
    S_REL_WALK,
    S_REL_FREE,
    S_EMIT
  } state_e;

endpackage

// ===== hw/rtl/linked_free_list_slot_allocator.sv =====
// ============================================================================
// linked_free_list_slot_allocator
// Slot pool kept on a free list and an active list, both linked in RAM.
// ============================================================================
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_word_i): kind 0 allocates
//   the free-list head and pushes it onto the active list with a number one
//   above the previous active head's (0 if none); kind 1 releases the named
//   slot. Result channel (out_valid_o / out_stall_i / out_word_o) returns one
//   word per request, always carrying the current active-list head.
//   Sequence: an allocate passes S_ALLOC_UPD then S_EMIT; a rejected request
//   goes straight to S_EMIT. A release passes S_REL_HEAD, then S_REL_WALK
//   walks k active-list links to find the predecessor (k = 0 when the slot
//   is the head, at most POOL_SLOTS + 1), one link RAM read per cycle, then
//   S_REL_FREE and S_EMIT. That walk sets the release rate; a new request is
//   taken once the sequencer is idle.
//   Reset: all slots on the free list in index order, active list empty.
//   No clearing pass: per-entry written bits select the reset contents.
//   Receiver stall: a finished word sits in the result register while the
//   next request is accepted and processed; the sequencer only waits at its
//   final step if the result register is still full and stalled.
// ============================================================================
module linked_free_list_slot_allocator #(
  parameter int POOL_SLOTS  = 32,
  parameter int NUMBER_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lfsa_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lfsa_pkg::out_word_t  out_word_o
);

  import lfsa_pkg::*;

  localparam int IDX_W  = $clog2(POOL_SLOTS);
  localparam int LINK_W = $clog2(POOL_SLOTS + 1);
  localparam int STEP_W = $clog2(POOL_SLOTS + 1);
  localparam logic [LINK_W-1:0] NIL       = LINK_W'(POOL_SLOTS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(POOL_SLOTS);

  // Width helpers onto the fixed result fields
  function automatic logic [4:0] to_slot5(input logic [LINK_W-1:0] v);
    logic [LINK_W+4:0] e;
    e = {5'b0, v};
    return e[4:0];
  endfunction

  function automatic logic [7:0] to_num8(input logic [NUMBER_BITS-1:0] v);
    logic [NUMBER_BITS+7:0] e;
    e = {8'b0, v};
    return e[7:0];
  endfunction

  // Control state
  state_e                  state_q, state_d;
  logic [LINK_W-1:0]       free_head_q, free_head_d;
  logic [LINK_W-1:0]       active_first_q, active_first_d;
  logic [POOL_SLOTS-1:0]   active_q, active_d;
  logic [POOL_SLOTS-1:0]   link_wr_q, num_wr_q;
  logic                    out_valid_q, out_valid_d;

  // Working registers
  logic [LINK_W-1:0]       slot_q, slot_d;
  logic [LINK_W-1:0]       ls_q, ls_d;
  logic [LINK_W-1:0]       p_q, p_d;
  logic [STEP_W-1:0]       steps_q, steps_d;
  out_word_t               res_q, res_d;
  out_word_t               out_q, out_d;

  // RAM ports
  logic                    link_we, num_we;
  logic [IDX_W-1:0]        link_waddr, link_raddr, num_waddr, num_raddr;
  logic [LINK_W-1:0]       link_wdata, link_ram;
  logic [NUMBER_BITS-1:0]  num_wdata, num_ram;
  logic [IDX_W-1:0]        link_rd_addr_q, num_rd_addr_q;
  logic                    link_rd_init_q, num_rd_init_q;
  logic [LINK_W-1:0]       link_rd;
  logic [NUMBER_BITS-1:0]  num_rd, num_new;

  // Request decode
  logic                    in_fire, out_free, s_in_pool, s_active;
  logic [LINK_W+4:0]       s_ext;
  logic [LINK_W-1:0]       s_lw;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s_ext      = {LINK_W'(0), in_word_i.slot};
  assign s_lw       = s_ext[LINK_W-1:0];
  assign s_in_pool  = (s_ext < (LINK_W + 5)'(POOL_SLOTS));
  assign s_active   = s_in_pool && active_q[s_lw[IDX_W-1:0]];

  // Link and number storage
  lfsa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_ram)
  );

  lfsa_ram #(.WIDTH(NUMBER_BITS), .DEPTH(POOL_SLOTS)) u_num_ram (
    .clk_i   (clk_i),
    .we_i    (num_we),
    .waddr_i (num_waddr),
    .wdata_i (num_wdata),
    .raddr_i (num_raddr),
    .rdata_o (num_ram)
  );

  // Unwritten entries read as their reset contents
  assign link_rd = link_rd_init_q ? (LINK_W'(link_rd_addr_q) + LINK_W'(1)) : link_ram;
  assign num_rd  = num_rd_init_q ? NUMBER_BITS'(num_rd_addr_q) : num_ram;
  assign num_new = (active_first_q == NIL) ? '0 : (num_rd + NUMBER_BITS'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_word_i.kind == KIND_ALLOC) begin
            state_d = (free_head_q == NIL) ? S_EMIT : S_ALLOC_UPD;
          end else begin
            state_d = s_active ? S_REL_HEAD : S_EMIT;
          end
        end
      end
      S_ALLOC_UPD: state_d = S_EMIT;
      S_REL_HEAD:  state_d = (active_first_q == slot_q) ? S_REL_FREE : S_REL_WALK;
      S_REL_WALK: begin
        if (link_rd == slot_q || link_rd == NIL || steps_q == STEP_LAST) begin
          state_d = S_REL_FREE;
        end
      end
      S_REL_FREE:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    free_head_d    = free_head_q;
    active_first_d = active_first_q;
    active_d       = active_q;
    slot_d         = slot_q;
    ls_d           = ls_q;
    p_d            = p_q;
    steps_d        = steps_q;
    res_d          = res_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && out_stall_i;
    link_we        = 1'b0;
    link_waddr     = free_head_q[IDX_W-1:0];
    link_wdata     = active_first_q;
    link_raddr     = '0;
    num_we         = 1'b0;
    num_waddr      = free_head_q[IDX_W-1:0];
    num_wdata      = num_new;
    num_raddr      = (active_first_q == NIL) ? '0 : active_first_q[IDX_W-1:0];

    unique case (state_q)
      // Take a request; reject or start the RAM reads
      S_IDLE: begin
        if (in_fire) begin
          slot_d = s_lw;
          if (in_word_i.kind == KIND_ALLOC) begin
            res_d        = '0;
            res_d.status = STATUS_POOL_EMPTY;
            link_raddr   = free_head_q[IDX_W-1:0];
          end else begin
            res_d              = '0;
            res_d.status       = STATUS_NOT_ACTIVE;
            res_d.granted_slot = in_word_i.slot;
            link_raddr         = s_lw[IDX_W-1:0];
          end
        end
      end
      // Pop free head, push onto active list
      S_ALLOC_UPD: begin
        free_head_d                        = link_rd;
        link_we                            = 1'b1;
        num_we                             = 1'b1;
        active_first_d                     = free_head_q;
        active_d[free_head_q[IDX_W-1:0]]   = 1'b1;
        res_d                              = '0;
        res_d.status                       = STATUS_OK;
        res_d.granted_slot                 = to_slot5(free_head_q);
        res_d.slot_number                  = to_num8(num_new);
      end
      // Successor of the released slot is in; start the walk if needed
      S_REL_HEAD: begin
        ls_d = link_rd;
        if (active_first_q == slot_q) begin
          active_first_d = link_rd;
        end else begin
          p_d        = active_first_q;
          steps_d    = '0;
          link_raddr = active_first_q[IDX_W-1:0];
        end
      end
      // One link per cycle until the predecessor, the list end or the step bound is reached
      S_REL_WALK: begin
        if (link_rd == slot_q) begin
          link_we    = 1'b1;
          link_waddr = p_q[IDX_W-1:0];
          link_wdata = ls_q;
        end else if (!(link_rd == NIL || steps_q == STEP_LAST)) begin
          p_d        = link_rd;
          steps_d    = steps_q + STEP_W'(1);
          link_raddr = link_rd[IDX_W-1:0];
        end
      end
      // Push released slot onto free list
      S_REL_FREE: begin
        link_we                       = 1'b1;
        link_waddr                    = slot_q[IDX_W-1:0];
        link_wdata                    = free_head_q;
        free_head_d                   = slot_q;
        active_d[slot_q[IDX_W-1:0]]   = 1'b0;
        res_d                         = '0;
        res_d.status                  = STATUS_OK;
        res_d.granted_slot            = to_slot5(slot_q);
      end
      // Load the result register with the current active head
      S_EMIT: begin
        if (out_free) begin
          out_d              = res_q;
          out_d.active_empty = (active_first_q == NIL);
          out_d.active_head  = (active_first_q == NIL) ? 5'd0 : to_slot5(active_first_q);
          out_valid_d        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      free_head_q    <= '0;
      active_first_q <= NIL;
      active_q       <= '0;
      link_wr_q      <= '0;
      num_wr_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      free_head_q    <= free_head_d;
      active_first_q <= active_first_d;
      active_q       <= active_d;
      out_valid_q    <= out_valid_d;
      if (link_we) begin
        link_wr_q[link_waddr] <= 1'b1;
      end
      if (num_we) begin
        num_wr_q[num_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q         <= slot_d;
    ls_q           <= ls_d;
    p_q            <= p_d;
    steps_q        <= steps_d;
    res_q          <= res_d;
    out_q          <= out_d;
    link_rd_addr_q <= link_raddr;
    link_rd_init_q <= !link_wr_q[link_raddr];
    num_rd_addr_q  <= num_raddr;
    num_rd_init_q  <= !num_wr_q[num_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  a_heads_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(free_head_q == active_first_q && free_head_q != NIL))
    else $error("free and active list share a head");

  a_head_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_first_q != NIL) |-> active_q[active_first_q[IDX_W-1:0]])
    else $error("active head not flagged active");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded on emit");

endmodule

// ===== hw/rtl/lfsa_ram.sv =====
// ============================================================================
// lfsa_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ============================================================================
module lfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/linked_free_list_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// linked_free_list_slot_allocator_tb
// Self-checking bench for the slot allocator: a behavioral copy of the free
// and active lists predicts every result word, which is compared field by
// field with the word the block returns. Directed cases, pool exhaustion,
// slot-number wrap and a random allocate/release mix run with random gaps
// on the request side and random stalls on the result side.
// ============================================================================
module linked_free_list_slot_allocator_tb;
  import lfsa_pkg::*;

  localparam int          SLOTS       = 32;
  localparam logic [5:0]  NIL         = 6'd32;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_WAIT  = 60;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  linked_free_list_slot_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the allocator lists
  logic [5:0] slot_link   [SLOTS];
  logic [7:0] slot_number [SLOTS];
  logic       slot_busy   [SLOTS];
  logic [5:0] free_first;
  logic [5:0] busy_first;

  out_word_t   expected_words[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          tx_idle_on     = 1'b1;
  bit          rx_stall_on    = 1'b1;
  int unsigned rx_run         = 0;

  function automatic void lists_reset();
    for (int i = 0; i < SLOTS; i++) begin
      slot_link[i]   = 6'(i + 1);
      slot_number[i] = 8'(i);
      slot_busy[i]   = 1'b0;
    end
    free_first = 6'd0;
    busy_first = NIL;
  endfunction

  function automatic out_word_t result_word(logic [1:0] status, logic [4:0] granted,
                                            logic [7:0] number);
    out_word_t w;
    w.status       = status;
    w.granted_slot = granted;
    w.slot_number  = number;
    w.active_empty = (busy_first == NIL);
    w.active_head  = w.active_empty ? 5'd0 : busy_first[4:0];
    return w;
  endfunction

  // Apply one request to the shadow lists and return the word it produces
  function automatic out_word_t allocator_step(in_word_t req);
    logic [5:0] g;
    logic [5:0] p;
    logic [7:0] num;
    int         steps;
    if (req.kind == KIND_ALLOC) begin
      if (free_first == NIL) return result_word(STATUS_POOL_EMPTY, 5'd0, 8'd0);
      g          = free_first;
      free_first = slot_link[g];
      num        = (busy_first == NIL) ? 8'd0 : slot_number[busy_first] + 8'd1;
      slot_link[g]   = busy_first;
      busy_first     = g;
      slot_number[g] = num;
      slot_busy[g]   = 1'b1;
      return result_word(STATUS_OK, g[4:0], num);
    end
    if (!slot_busy[req.slot]) return result_word(STATUS_NOT_ACTIVE, req.slot, 8'd0);
    if (busy_first == {1'b0, req.slot}) begin
      busy_first = slot_link[req.slot];
    end else begin
      // predecessor search, bounded by the pool size
      p     = busy_first;
      steps = 0;
      while (p != NIL && slot_link[p] != {1'b0, req.slot} && steps < SLOTS) begin
        p = slot_link[p];
        steps++;
      end
      if (p != NIL && slot_link[p] == {1'b0, req.slot}) slot_link[p] = slot_link[req.slot];
    end
    slot_link[req.slot] = free_first;
    free_first          = {1'b0, req.slot};
    slot_busy[req.slot] = 1'b0;
    return result_word(STATUS_OK, req.slot, 8'd0);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [4:0] pick_busy_slot();
    int unsigned cand[$];
    for (int i = 0; i < SLOTS; i++) if (slot_busy[i]) cand.push_back(i);
    if (cand.size() == 0) return 5'($urandom_range(31));
    return 5'(cand[$urandom_range(cand.size() - 1)]);
  endfunction

  // Send one request word; predict its result once it is taken
  task automatic send_word(input logic kind, input logic [4:0] slot, output out_word_t pred);
    in_word_t    req;
    int unsigned gap;
    req.kind   = kind;
    req.slot   = slot;
    in_valid_i <= 1'b1;
    in_word_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pred = allocator_step(req);
    expected_words.push_back(pred);
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Empty list, head/middle/tail release, stale and double release, reuse
  task automatic test_directed();
    out_word_t w;
    send_word(KIND_RELEASE, 5'd0,  w);
    send_word(KIND_RELEASE, 5'd31, w);
    send_word(KIND_ALLOC,   5'h1f, w);
    send_word(KIND_ALLOC,   5'd0,  w);
    send_word(KIND_ALLOC,   5'h15, w);
    send_word(KIND_RELEASE, 5'd0,  w);
    send_word(KIND_RELEASE, 5'd2,  w);
    send_word(KIND_RELEASE, 5'd2,  w);
    send_word(KIND_ALLOC,   5'h0a, w);
    send_word(KIND_ALLOC,   5'd0,  w);
    send_word(KIND_ALLOC,   5'd0,  w);
    send_word(KIND_RELEASE, 5'd0,  w);
    send_word(KIND_RELEASE, 5'd1,  w);
    send_word(KIND_RELEASE, 5'd3,  w);
    send_word(KIND_RELEASE, 5'd2,  w);
    send_word(KIND_ALLOC,   5'd7,  w);
    send_word(KIND_RELEASE, 5'd30, w);
    send_word(KIND_RELEASE, pick_busy_slot(), w);
  endtask

  // Fill the pool past empty, then drain it with long walks
  task automatic test_pool_exhaust();
    out_word_t w;
    for (int i = 0; i < SLOTS + 3; i++) send_word(KIND_ALLOC, 5'($urandom_range(31)), w);
    while (busy_first != NIL) send_word(KIND_RELEASE, pick_busy_slot(), w);
    send_word(KIND_RELEASE, 5'($urandom_range(31)), w);
  endtask

  // Chain of alloc + release-older pairs walks the number past 255
  task automatic test_number_wrap();
    out_word_t  w;
    logic [4:0] older;
    send_word(KIND_ALLOC, 5'd0, w);
    older = w.granted_slot;
    for (int i = 0; i < 262; i++) begin
      tx_idle_on  = (i < 130);
      rx_stall_on = (i < 80) || (i >= 180);
      send_word(KIND_ALLOC, 5'($urandom_range(31)), w);
      send_word(KIND_RELEASE, older, w);
      older = w.granted_slot == older ? older : older;
      older = busy_first[4:0];
    end
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    send_word(KIND_RELEASE, older, w);
  endtask

  // Random mix in phases that lean toward allocate, stay balanced, or lean toward release
  task automatic test_random_mix();
    out_word_t   w;
    int unsigned alloc_pct;
    logic [4:0]  slot;
    for (int phase = 0; phase < 6; phase++) begin
      alloc_pct   = (phase % 3 == 0) ? 75 : (phase % 3 == 1) ? 50 : 25;
      tx_idle_on  = (phase != 2);
      rx_stall_on = (phase != 4);
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(99) < alloc_pct) begin
          send_word(KIND_ALLOC, 5'($urandom_range(31)), w);
        end else begin
          slot = ($urandom_range(99) < 85) ? pick_busy_slot() : 5'($urandom_range(31));
          send_word(KIND_RELEASE, slot, w);
        end
      end
    end
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  // Result side: random stall runs
  always @(posedge clk_i) begin
    if (rx_run == 0) begin
      out_stall_i <= rx_stall_on && ($urandom_range(2) == 0);
      rx_run      <= pick_gap();
    end else begin
      rx_run <= rx_run - 1;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %p", out_word_o);
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word_o.status       !== exp_w.status       ||
            out_word_o.granted_slot !== exp_w.granted_slot ||
            out_word_o.slot_number  !== exp_w.slot_number  ||
            out_word_o.active_head  !== exp_w.active_head  ||
            out_word_o.active_empty !== exp_w.active_empty) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: expected %p, got %p", $realtime, exp_w, out_word_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    lists_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_pool_exhaust();
    test_number_wrap();
    test_random_mix();

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
